>>> rtl/nsq_pkg.sv
// Types and fixed constants for the Newton-Raphson fixed-point square root.
// No dependencies; used by the channel interfaces and the top level.
package nsq_pkg;

    localparam int VALUE_W    = 32;          // width of value, root and tolerance
    localparam int PROD_W     = 2 * VALUE_W; // full square / numerator width
    localparam int STEP_CNT_W = 6;           // width of the step_count field
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    localparam logic [VALUE_W-1:0] TOL_RESET = VALUE_W'(655);
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ERROR,
        ST_TEST,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } t_state;

endpackage

>>> rtl/nsq_if.sv
// Valid/ready channels for the square root block: input value and result.
// Depends on nsq_pkg for field widths.
interface nsq_in_if;
    logic                         valid;
    logic                         ready;
    logic [nsq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface nsq_out_if;
    logic                            valid;
    logic                            ready;
    logic [nsq_pkg::VALUE_W-1:0]     root;
    logic [nsq_pkg::STEP_CNT_W-1:0]  step_count;
    logic                            converged;

    modport source (output valid, output root, output step_count, output converged,
                    input ready);
    modport sink   (input valid, input root, input step_count, input converged,
                    output ready);
endinterface

>>> rtl/newton_square_root_fixed.sv
// Each Newton step runs the square, error, test, restoring divide and update states in turn;
// the test state ends the run once the error is within tolerance or the step limit is reached.
// A new value enters only in idle, after the last is done; the bit-serial divider dominates.
// A finished result sits in an output register, so the next value may enter meanwhile.
// Reset (synchronous, active low) empties the sequencer and output, tolerance -> 655.
// Depends on nsq_pkg and the channel interfaces in nsq_if.sv.
module newton_square_root_fixed #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_ITER  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nsq_pkg::VALUE_W-1:0]  i_cfg_data,
    nsq_in_if.sink                       i_in,
    nsq_out_if.source                    o_res
);

    localparam int W      = nsq_pkg::VALUE_W;
    localparam int PW     = nsq_pkg::PROD_W;
    localparam int STEP_W = $clog2(MAX_ITER + 1);
    localparam int CW     = nsq_pkg::STEP_CNT_W;

    localparam logic [W-1:0]      ONE_FIX  = W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] ITER_LIM = STEP_W'(MAX_ITER);
    localparam logic [nsq_pkg::DIV_CNT_W-1:0] DIV_LAST = nsq_pkg::DIV_CNT_W'(PW - 1);

    nsq_pkg::t_state r_state, n_state;

    logic [W-1:0]      r_tol;
    logic [W-1:0]      r_value;
    logic [W-1:0]      r_x;
    logic [STEP_W-1:0] r_step;
    logic [PW-1:0]     r_prod;
    logic [PW-1:0]     r_mag;
    logic              r_above;
    logic              r_conv;
    // divider: numerator shifts out as quotient bits shift in
    logic [PW-1:0]     r_num;
    logic [W:0]        r_div;
    logic [W:0]        r_rem;
    logic [nsq_pkg::DIV_CNT_W-1:0] r_dcnt;

    logic              r_out_valid;
    logic [W-1:0]      r_out_root;
    logic [CW-1:0]     r_out_steps;
    logic              r_out_conv;

    logic in_ready, out_load, in_fire;
    logic tol_met, iter_done, div_last;

    logic [PW-1:0]     sq;
    logic [PW-1:0]     val_ext;
    logic              sq_above;
    logic [W+1:0]      rem_shift;
    logic [W+1:0]      rem_diff;
    logic              q_bit;
    logic [PW:0]       x_sum;
    logic [W-1:0]      x_next;
    logic [STEP_W+CW-1:0] step_ext;

    assign in_fire   = i_in.valid && in_ready;
    assign tol_met   = r_mag <= {{(PW-W){1'b0}}, r_tol};
    assign iter_done = r_step >= ITER_LIM;
    assign div_last  = r_dcnt == DIV_LAST;

    // error term |x*x - v|, square truncated to FRAC_BITS fraction bits
    assign sq       = r_prod >> FRAC_BITS;
    assign val_ext  = {{(PW-W){1'b0}}, r_value};
    assign sq_above = sq >= val_ext;

    // one restoring division step
    assign rem_shift = {r_rem, r_num[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, r_div};
    assign q_bit     = !rem_diff[W+1];

    // Newton update, clamped to [1 LSB, all ones]
    assign x_sum = {1'b0, r_num} + {{(PW-W+1){1'b0}}, r_x};
    always_comb begin
        if (r_above) begin
            if (r_num >= {{(PW-W){1'b0}}, r_x}) begin
                x_next = W'(1);
            end else begin
                x_next = r_x - r_num[W-1:0];
            end
        end else if (x_sum[PW:W] != '0) begin
            x_next = nsq_pkg::VALUE_MAX;
        end else begin
            x_next = x_sum[W-1:0];
        end
    end

    assign step_ext = {{CW{1'b0}}, r_step};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsq_pkg::ST_IDLE:   if (i_in.valid) n_state = nsq_pkg::ST_SQUARE;
            nsq_pkg::ST_SQUARE: n_state = nsq_pkg::ST_ERROR;
            nsq_pkg::ST_ERROR:  n_state = nsq_pkg::ST_TEST;
            nsq_pkg::ST_TEST: begin
                if (tol_met || iter_done) n_state = nsq_pkg::ST_FINISH;
                else                      n_state = nsq_pkg::ST_DIVIDE;
            end
            nsq_pkg::ST_DIVIDE: if (div_last) n_state = nsq_pkg::ST_UPDATE;
            nsq_pkg::ST_UPDATE: n_state = nsq_pkg::ST_SQUARE;
            nsq_pkg::ST_FINISH: if (out_load) n_state = nsq_pkg::ST_IDLE;
            default:            n_state = nsq_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            nsq_pkg::ST_IDLE:   in_ready = 1'b1;
            nsq_pkg::ST_FINISH: out_load = !r_out_valid || o_res.ready;
            default: begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nsq_pkg::ST_IDLE;
            r_tol       <= nsq_pkg::TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            nsq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    r_value <= i_in.value;
                    r_step  <= '0;
                    if (i_in.value != '0 && i_in.value < ONE_FIX) begin
                        r_x <= ONE_FIX;
                    end else begin
                        r_x <= i_in.value;
                    end
                end
            end
            nsq_pkg::ST_SQUARE: r_prod <= PW'(r_x) * PW'(r_x);
            nsq_pkg::ST_ERROR: begin
                r_above <= sq_above;
                r_mag   <= sq_above ? sq - val_ext : val_ext - sq;
            end
            nsq_pkg::ST_TEST: begin
                r_conv <= tol_met;
                r_num  <= r_mag << FRAC_BITS;
                r_div  <= {r_x, 1'b0};
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            nsq_pkg::ST_DIVIDE: begin
                r_rem  <= q_bit ? rem_diff[W:0] : rem_shift[W:0];
                r_num  <= {r_num[PW-2:0], q_bit};
                r_dcnt <= r_dcnt + 1'b1;
            end
            nsq_pkg::ST_UPDATE: begin
                r_x    <= x_next;
                r_step <= r_step + 1'b1;
            end
            nsq_pkg::ST_FINISH: begin
                if (out_load) begin
                    r_out_root  <= r_x;
                    r_out_steps <= step_ext[CW-1:0];
                    r_out_conv  <= r_conv;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign i_in.ready       = in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.root       = r_out_root;
    assign o_res.step_count = r_out_steps;
    assign o_res.converged  = r_out_conv;

endmodule
